/* rtl/core/wsd_pkg.sv */
// shared types and constants for the websocket frame deframer
`default_nettype none

package wsd_pkg;

   // result kind codes
   typedef enum logic [2:0] {
      KIND_DATA   = 3'd0,
      KIND_PING   = 3'd1,
      KIND_CLOSE  = 3'd2,
      KIND_LENERR = 3'd3,
      KIND_EMPTY  = 3'd4
   } kind_type;

   // opcodes and length codes of the frame header
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // one result item without its valid bit
   typedef struct packed {
      logic [7:0]  data;
      kind_type    kind;
      logic        first;
      logic        last;
      logic [3:0]  opcode;
      logic [15:0] length;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/wsd_parser.sv */
// frame header parser and payload unmasker, one byte per enabled cycle
`default_nettype none

module wsd_parser (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 step_en,
   input  wire  [7:0]          step_byte,
   output logic                res_valid,
   output wsd_pkg::result_type res
);
   import wsd_pkg::*;

   logic [3:0]  header_count_ff, header_count_in;
   logic [7:0]  first_byte_ff, first_byte_in;
   logic [7:0]  second_byte_ff, second_byte_in;
   logic [15:0] payload_length_ff, payload_length_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [15:0] payload_count_ff, payload_count_in;
   logic [3:0]  saved_opcode_ff, saved_opcode_in;
   logic        halted_ff, halted_in;

   // full header length for a given second header byte
   function automatic logic [3:0] header_len(input logic [7:0] second);
      logic [3:0] n;
      n = 4'd2;
      if (second[6:0] == LEN_EXT16) n = n + 4'd2;
      if (second[7]) n = n + 4'd4;
      return n;
   endfunction

   // carries payload bytes out: every opcode below close, and ping
   function automatic logic carries_bytes(input logic [3:0] op);
      return (op < OP_CLOSE) || (op == OP_PING);
   endfunction

   logic [3:0]  raw_op;
   logic [3:0]  hlen;
   logic        do_finish;
   logic [7:0]  key_byte;
   logic [16:0] count_next;
   logic        last_byte;

   assign raw_op = first_byte_ff[3:0];
   assign hlen   = header_len(second_byte_ff);

   // mask key byte chosen by payload offset
   always_comb begin
      case (payload_count_ff[1:0])
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   assign count_next = {1'b0, payload_count_ff} + 17'd1;
   assign last_byte  = count_next >= {1'b0, payload_length_ff};

   // next state and result for one byte
   always_comb begin
      header_count_in   = header_count_ff;
      first_byte_in     = first_byte_ff;
      second_byte_in    = second_byte_ff;
      payload_length_in = payload_length_ff;
      mask_key_in       = mask_key_ff;
      payload_count_in  = payload_count_ff;
      saved_opcode_in   = saved_opcode_ff;
      halted_in         = halted_ff;
      do_finish         = 1'b0;
      res_valid         = 1'b0;
      res.data          = 8'd0;
      res.kind          = KIND_DATA;
      res.first         = 1'b0;
      res.last          = 1'b0;
      res.length        = 16'd0;

      if (step_en && !halted_ff) begin
         if (header_count_ff == 4'd0) begin
            // first header byte: fin and opcode
            first_byte_in   = step_byte;
            header_count_in = 4'd1;
         end else if (header_count_ff == 4'd1) begin
            // second header byte: mask bit and length code
            second_byte_in  = step_byte;
            header_count_in = 4'd2;
            mask_key_in     = 32'd0;
            if (step_byte[6:0] == LEN_EXT64) begin
               halted_in = 1'b1;
               res_valid = 1'b1;
               res.kind  = KIND_LENERR;
            end else begin
               payload_length_in = (step_byte[6:0] < LEN_EXT16) ?
                                   {9'd0, step_byte[6:0]} : 16'd0;
               do_finish = (header_len(step_byte) == 4'd2);
            end
         end else if (header_count_ff < hlen) begin
            // extended length, then mask key
            if ((second_byte_ff[6:0] == LEN_EXT16) && (header_count_ff < 4'd4)) begin
               payload_length_in = {payload_length_ff[7:0], step_byte};
            end else begin
               mask_key_in = {mask_key_ff[23:0], step_byte};
            end
            header_count_in = header_count_ff + 4'd1;
            do_finish       = (header_count_in == hlen);
         end else begin
            // payload byte
            payload_count_in = count_next[15:0];
            if (last_byte) header_count_in = 4'd0;
            if (carries_bytes(raw_op)) begin
               res_valid  = 1'b1;
               res.data   = step_byte ^ key_byte;
               res.kind   = (raw_op == OP_PING) ? KIND_PING : KIND_DATA;
               res.first  = (payload_count_ff == 16'd0);
               res.last   = last_byte && first_byte_ff[7];
               res.length = payload_length_ff;
            end
         end

         // header complete
         if (do_finish) begin
            payload_count_in = 16'd0;
            if (raw_op == OP_CLOSE) begin
               halted_in  = 1'b1;
               res_valid  = 1'b1;
               res.kind   = KIND_CLOSE;
               res.length = payload_length_in;
            end else begin
               if ((raw_op < OP_CLOSE) && (raw_op != OP_CONT) && !first_byte_ff[7]) begin
                  saved_opcode_in = raw_op;
               end
               if (payload_length_in == 16'd0) begin
                  header_count_in = 4'd0;
                  if (carries_bytes(raw_op)) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_EMPTY;
                     res.first = 1'b1;
                     res.last  = first_byte_ff[7];
                  end
               end
            end
         end
      end

      // effective opcode: continuation frames report the saved one
      res.opcode = (raw_op == OP_CONT) ? saved_opcode_in : raw_op;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff   <= 4'd0;
         first_byte_ff     <= 8'd0;
         second_byte_ff    <= 8'd0;
         payload_length_ff <= 16'd0;
         mask_key_ff       <= 32'd0;
         payload_count_ff  <= 16'd0;
         saved_opcode_ff   <= 4'd0;
         halted_ff         <= 1'b0;
      end else begin
         header_count_ff   <= header_count_in;
         first_byte_ff     <= first_byte_in;
         second_byte_ff    <= second_byte_in;
         payload_length_ff <= payload_length_in;
         mask_key_ff       <= mask_key_in;
         payload_count_ff  <= payload_count_in;
         saved_opcode_ff   <= saved_opcode_in;
         halted_ff         <= halted_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/websocket_frame_deframer.sv */
// top level of the websocket client frame deframer
//
// The req channel takes the raw client byte stream, one byte per transfer.
// The block gathers each frame header (fin, opcode, mask bit, 7-bit or 16-bit
// length, mask key), then unmasks every payload byte and sends it on the rsp
// channel tagged as data or ping. Zero-length frames give one empty-frame item,
// a close frame gives one close item, and a 64-bit length code gives one
// length-error item; after close or length error the block swallows every byte
// until reset. Header bytes and frames with opcodes above ping give no item.
// A byte accepted into the input register is parsed from there, and its result is
// then registered in the result register, which drives rsp_tvalid.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single parse stage between the input register and the result register.
// When the receiver stalls with a result waiting, the byte in the input register
// waits too and req_tready follows rsp_tready; an empty input register still
// takes one byte. Reset is synchronous and clears all parser state and both
// valid flags; no warm-up is needed after it.
`default_nettype none

module websocket_frame_deframer (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,    // in_byte[7:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,    // out_byte[7:0], frame_opcode[11:8],
                                     // frame_length[27:12], zero[31:28]
   output logic [3:0]  rsp_tuser,    // out_kind[2:0], frame_first[3]
   output logic        rsp_tlast     // message_end
);
   import wsd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       advance;
   logic       step_valid;
   result_type step_res;

   // parse the held byte once the result register can take its result
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_byte (in_byte_ff),
      .res_valid (step_valid),
      .res       (step_res)
   );

   // input register
   always_comb begin
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;
      else                          in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // result register
   always_comb begin
      if (advance)         rsp_valid_in = step_valid;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_valid) begin
         rsp_ff <= step_res;
      end
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.length, rsp_ff.opcode, rsp_ff.data};
   assign rsp_tuser  = {rsp_ff.first, rsp_ff.kind};
   assign rsp_tlast  = rsp_ff.last;

endmodule

`default_nettype wire
